>>> hdl/rws_pkg.sv
// Shared types and constants for the roulette wheel selector.
package rws_pkg;

  localparam int POP_BITS      = 9;   // population register width
  localparam int ENTRY_BITS    = 8;   // load index width on the input
  localparam int LOAD_FIT_BITS = 32;  // fitness width on the input
  localparam int PICK_BITS     = 40;  // pick value width
  localparam int IDX_OUT_BITS  = 8;   // selected index width on the output

  localparam logic [POP_BITS-1:0] POP_RESET = 9'd256;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  // Token handed from cell to cell during a select
  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic [IDX_OUT_BITS-1:0] idx;
  } ctrl_t;

endpackage

>>> hdl/roulette_wheel_selector.sv
// Top level of the roulette wheel selector: input control, cell row, result registers.
//
//   channel  dir  payload                                               notes
//   in_      in   tdata: entry_index, fitness_value, pick_value         tuser = req_type
//   out_     out  tdata: selected_index                                 tuser = found
//   cfg_     in   wr_data: population_in_use                            write on cfg_wr_en
//
// A load writes the addressed cell directly.
// A select walks the token from the start register through all POP_DEPTH cells, one per cycle,
// into the output register or the skid slot; in_tready stays low meanwhile.
// A result waiting on out_tready does not block input; a second one parks in a skid stage.
// Reset clears control only; fitness cells hold garbage until loaded.
module roulette_wheel_selector
  import rws_pkg::*;
#(
  parameter int POP_DEPTH    = 256,
  parameter int FITNESS_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // [7:0] entry_index, [39:8] fitness_value, [79:40] pick_value
  input  logic [79:0]             in_tdata,
  // [0] req_type
  input  logic [0:0]              in_tuser,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // [7:0] selected_index
  output logic [7:0]              out_tdata,
  // [0] found
  output logic [0:0]              out_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic                    cfg_wr_en,
  input  logic [POP_BITS-1:0]     cfg_wr_data
);

  localparam int CNT_W = $clog2(POP_DEPTH + 1);
  localparam int SUM_W = FITNESS_BITS + $clog2(POP_DEPTH);
  localparam int SAT_W = (CNT_W > POP_BITS) ? CNT_W : POP_BITS;
  localparam logic [SAT_W-1:0] DEPTH_S = SAT_W'(POP_DEPTH);

  logic [ENTRY_BITS-1:0]    in_idx;
  logic [LOAD_FIT_BITS-1:0] in_fit;
  logic [PICK_BITS-1:0]     in_pick;
  logic                     in_fire;
  logic                     sel_fire;
  logic                     wr_en;
  logic [FITNESS_BITS-1:0]  wr_fit;

  logic [POP_BITS-1:0]      pop_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_sat;
  logic [SAT_W-1:0]         pop_s;
  logic [PICK_BITS-1:0]     pick_r;
  logic                     start_r;
  logic                     busy_r;

  ctrl_t                    ctrl_chain [0:POP_DEPTH];
  logic [SUM_W-1:0]         sum_chain  [0:POP_DEPTH];
  ctrl_t                    res;

  logic                     out_v_r, out_v_nxt;
  logic [IDX_OUT_BITS-1:0]  out_idx_r, out_idx_nxt;
  logic                     out_found_r, out_found_nxt;
  logic                     skid_v_r, skid_v_nxt;
  logic [IDX_OUT_BITS-1:0]  skid_idx_r, skid_idx_nxt;
  logic                     skid_found_r, skid_found_nxt;
  logic                     out_free;

  assign in_idx   = in_tdata[7:0];
  assign in_fit   = in_tdata[39:8];
  assign in_pick  = in_tdata[79:40];
  assign in_tready = !busy_r && !skid_v_r;
  assign in_fire  = in_tvalid && in_tready;
  assign sel_fire = in_fire && (in_tuser[0] == REQ_SELECT);
  assign wr_en    = in_fire && (in_tuser[0] == REQ_LOAD);
  assign wr_fit   = FITNESS_BITS'(in_fit);

  assign pop_s     = SAT_W'(pop_r);
  assign count_sat = (pop_s > DEPTH_S) ? CNT_W'(DEPTH_S) : CNT_W'(pop_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r   <= POP_RESET;
      start_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pop_r <= cfg_wr_data;
      end
      start_r <= sel_fire;
      if (sel_fire) begin
        busy_r <= 1'b1;
      end else if (res.valid) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel_fire) begin
      pick_r  <= in_pick;
      count_r <= count_sat;
    end
  end

  // token enters cell 0 with an empty running sum
  assign ctrl_chain[0] = '{valid: start_r, found: 1'b0, idx: '0};
  assign sum_chain[0]  = '0;

  for (genvar g = 0; g < POP_DEPTH; g++) begin : g_cell
    rws_cell #(
      .INDEX        (g),
      .FITNESS_BITS (FITNESS_BITS),
      .SUM_W        (SUM_W),
      .CNT_W        (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl_i   (ctrl_chain[g]),
      .sum_i    (sum_chain[g]),
      .pick_i   (pick_r),
      .count_i  (count_r),
      .wr_en_i  (wr_en),
      .wr_idx_i (in_idx),
      .wr_fit_i (wr_fit),
      .ctrl_o   (ctrl_chain[g+1]),
      .sum_o    (sum_chain[g+1])
    );
  end

  assign res = ctrl_chain[POP_DEPTH];

  // output register plus one skid slot
  assign out_free = !out_v_r || out_tready;

  always_comb begin
    out_v_nxt      = out_v_r;
    out_idx_nxt    = out_idx_r;
    out_found_nxt  = out_found_r;
    skid_v_nxt     = skid_v_r;
    skid_idx_nxt   = skid_idx_r;
    skid_found_nxt = skid_found_r;
    priority if (skid_v_r && out_free) begin
      out_v_nxt      = 1'b1;
      out_idx_nxt    = skid_idx_r;
      out_found_nxt  = skid_found_r;
      skid_v_nxt     = res.valid;
      skid_idx_nxt   = res.idx;
      skid_found_nxt = res.found;
    end else if (res.valid && out_free) begin
      out_v_nxt     = 1'b1;
      out_idx_nxt   = res.idx;
      out_found_nxt = res.found;
    end else if (res.valid) begin
      skid_v_nxt     = 1'b1;
      skid_idx_nxt   = res.idx;
      skid_found_nxt = res.found;
    end else if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r    <= out_idx_nxt;
    out_found_r  <= out_found_nxt;
    skid_idx_r   <= skid_idx_nxt;
    skid_found_r <= skid_found_nxt;
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_idx_r;
  assign out_tuser[0] = out_found_r;

`ifndef ASSERT_OFF
  a_res_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> busy_r)
    else $error("select result left the cell row with no select in flight");

  a_select_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sel_fire |=> busy_r && start_r)
    else $error("accepted select did not launch a token");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot holds a result while output register is empty");

  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_v_r)
    else $error("select finished without a registered result");
`endif

endmodule

>>> hdl/rws_cell.sv
// One wheel cell: holds one fitness entry and advances the select token by one slot.
module rws_cell
  import rws_pkg::*;
#(
  parameter int INDEX        = 0,
  parameter int FITNESS_BITS = 32,
  parameter int SUM_W        = 40,
  parameter int CNT_W        = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_t                   ctrl_i,
  input  logic [SUM_W-1:0]        sum_i,
  input  logic [PICK_BITS-1:0]    pick_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic                    wr_en_i,
  input  logic [ENTRY_BITS-1:0]   wr_idx_i,
  input  logic [FITNESS_BITS-1:0] wr_fit_i,
  output ctrl_t                   ctrl_o,
  output logic [SUM_W-1:0]        sum_o
);

  localparam int CMP_W = (SUM_W > PICK_BITS) ? SUM_W : PICK_BITS;
  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);
  // cells beyond the input index range can never be loaded
  localparam bit REACHABLE = ((INDEX >> ENTRY_BITS) == 0);

  logic [FITNESS_BITS-1:0] fit_r;
  ctrl_t                   ctrl_r;
  ctrl_t                   ctrl_nxt;
  logic [SUM_W-1:0]        sum_r;
  logic [SUM_W-1:0]        sum_nxt;
  logic [SUM_W-1:0]        sum_add;
  logic                    live;
  logic                    hit;
  logic                    wr_hit;

  assign wr_hit  = REACHABLE && wr_en_i && (wr_idx_i == ENTRY_BITS'(INDEX));
  assign live    = ctrl_i.valid && !ctrl_i.found && (MY_IDX < count_i);
  assign sum_add = sum_i + SUM_W'(fit_r);
  assign hit     = CMP_W'(sum_add) >= CMP_W'(pick_i);

  always_comb begin
    ctrl_nxt = ctrl_i;
    sum_nxt  = sum_i;
    if (live) begin
      sum_nxt = sum_add;
      if (hit) begin
        ctrl_nxt.found = 1'b1;
        ctrl_nxt.idx   = IDX_OUT_BITS'(INDEX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      fit_r <= wr_fit_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign ctrl_o = ctrl_r;
  assign sum_o  = sum_r;

endmodule
